/* rtl/sat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

  localparam int unsigned ALARM_SLOTS_DEF = 16;
  localparam logic [7:0] SWITCH_PERIOD_RESET = 8'd36;

  typedef enum logic [1:0] {
    STATUS_SET_OK   = 2'd0,
    STATUS_NOT_TASK = 2'd1,
    STATUS_NO_SLOT  = 2'd2,
    STATUS_TICK     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SET_HEAD,
    ST_WALK,
    ST_NEXT,
    ST_LINK_NEW,
    ST_LINK_CUR,
    ST_TICK_HEAD,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

/* rtl/sat_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sat_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] delay_ticks;
  logic [7:0]  handler_id;
  logic        requester_is_task;

  modport source (output valid, mode, delay_ticks, handler_id, requester_is_task,
                  input ready);
  modport sink (input valid, mode, delay_ticks, handler_id, requester_is_task,
                output ready);
endinterface

`default_nettype wire

/* rtl/sat_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sat_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       alarm_fired;
  logic [7:0] fired_handler;
  logic       switch_request;

  modport source (output valid, status, alarm_fired, fired_handler, switch_request,
                  input ready);
  modport sink (input valid, status, alarm_fired, fired_handler, switch_request,
                output ready);
endinterface

`default_nettype wire

/* rtl/sorted_alarm_timer_queue.sv */
// Channel   Direction  Handshake      Payload
// req_i     in         valid / ready  mode, delay_ticks, handler_id, requester_is_task
// rsp_o     out        valid / ready  status, alarm_fired, fired_handler, switch_request
// cfg       in         cfg_we_i       cfg_wdata_i (switch_period)
//
// A tick reads the head slot (one slot read) when alarms are queued and skips the read with an empty list.
// A set from a task scans the busy flags one slot per cycle up to a free slot; an empty list
// takes a single write there. Otherwise it walks the sorted list, WALK then NEXT per entry,
// through the slot memory and ends with two writes, or with one write for a new head.
// Reset clears the counters, the busy flags and the list head; slot memory is not cleared.
// A stalled result stays in the output register while the next item is processed.
`timescale 1ns / 1ps
`default_nettype none

module sorted_alarm_timer_queue #(
  parameter int unsigned ALARM_SLOTS = sat_pkg::ALARM_SLOTS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  sat_req_if.sink         req_i,
  sat_rsp_if.source       rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int unsigned SW = $clog2(ALARM_SLOTS);

  typedef struct packed {
    logic [31:0]   deadline;
    logic [7:0]    handler;
    logic          has_next;
    logic [SW-1:0] next_idx;
  } slot_t;

  slot_t slot_mem_q [ALARM_SLOTS];
  slot_t rd_q;
  slot_t cur_q;
  slot_t wdata;
  logic          we;
  logic [SW-1:0] waddr;
  logic          rd_en;
  logic [SW-1:0] rd_addr;

  sat_pkg::state_e state_q, state_d;

  logic [7:0]             period_q;
  logic [31:0]            tick_q;
  logic [7:0]             switch_q;
  logic [ALARM_SLOTS-1:0] busy_q;
  logic                   nonempty_q;
  logic [SW-1:0]          head_q;
  logic [SW-1:0]          scan_q;
  logic [SW-1:0]          slot_q;
  logic [SW-1:0]          cur_idx_q;
  logic [31:0]            dl_q;
  logic [7:0]             hid_q;

  logic [1:0] res_status_q;
  logic       res_fired_q;
  logic [7:0] res_fh_q;
  logic       res_sw_q;

  logic       out_valid_q;
  logic [1:0] out_status_q;
  logic       out_fired_q;
  logic [7:0] out_fh_q;
  logic       out_sw_q;

  logic       accept;
  logic       out_free;
  logic       scan_free;
  logic       scan_last;
  logic [7:0] switch_inc;

  assign accept     = req_i.valid && req_i.ready;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign scan_free  = !busy_q[scan_q];
  assign scan_last  = (scan_q == SW'(ALARM_SLOTS - 1));
  assign switch_inc = switch_q + 8'd1;

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.alarm_fired    = out_fired_q;
  assign rsp_o.fired_handler  = out_fh_q;
  assign rsp_o.switch_request = out_sw_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sat_pkg::ST_IDLE: begin
        if (accept) begin
          if (!req_i.mode) begin
            state_d = nonempty_q ? sat_pkg::ST_TICK_HEAD : sat_pkg::ST_RESULT;
          end else if (!req_i.requester_is_task) begin
            state_d = sat_pkg::ST_RESULT;
          end else begin
            state_d = sat_pkg::ST_SCAN;
          end
        end
      end
      sat_pkg::ST_SCAN: begin
        if (scan_free) begin
          state_d = nonempty_q ? sat_pkg::ST_SET_HEAD : sat_pkg::ST_RESULT;
        end else if (scan_last) begin
          state_d = sat_pkg::ST_RESULT;
        end
      end
      sat_pkg::ST_SET_HEAD: begin
        state_d = (dl_q < rd_q.deadline) ? sat_pkg::ST_RESULT : sat_pkg::ST_WALK;
      end
      sat_pkg::ST_WALK: begin
        state_d = cur_q.has_next ? sat_pkg::ST_NEXT : sat_pkg::ST_LINK_NEW;
      end
      sat_pkg::ST_NEXT: begin
        state_d = (rd_q.deadline > dl_q) ? sat_pkg::ST_LINK_NEW : sat_pkg::ST_WALK;
      end
      sat_pkg::ST_LINK_NEW: state_d = sat_pkg::ST_LINK_CUR;
      sat_pkg::ST_LINK_CUR: state_d = sat_pkg::ST_RESULT;
      sat_pkg::ST_TICK_HEAD: state_d = sat_pkg::ST_RESULT;
      sat_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = sat_pkg::ST_IDLE;
        end
      end
      default: state_d = sat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    we          = 1'b0;
    waddr       = slot_q;
    wdata       = '{deadline: dl_q, handler: hid_q, has_next: 1'b0, next_idx: '0};
    unique case (state_q)
      sat_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        rd_en       = accept && !req_i.mode && nonempty_q;
      end
      sat_pkg::ST_SCAN: begin
        if (scan_free) begin
          rd_en = nonempty_q;
          we    = !nonempty_q;
          waddr = scan_q;
        end
      end
      sat_pkg::ST_SET_HEAD: begin
        if (dl_q < rd_q.deadline) begin
          we             = 1'b1;
          wdata.has_next = 1'b1;
          wdata.next_idx = head_q;
        end
      end
      sat_pkg::ST_WALK: begin
        rd_en   = cur_q.has_next;
        rd_addr = cur_q.next_idx;
      end
      sat_pkg::ST_LINK_NEW: begin
        we             = 1'b1;
        wdata.has_next = cur_q.has_next;
        wdata.next_idx = cur_q.next_idx;
      end
      sat_pkg::ST_LINK_CUR: begin
        we             = 1'b1;
        waddr          = cur_idx_q;
        wdata          = cur_q;
        wdata.has_next = 1'b1;
        wdata.next_idx = slot_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= slot_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sat_pkg::ST_IDLE;
      period_q     <= sat_pkg::SWITCH_PERIOD_RESET;
      tick_q       <= '0;
      switch_q     <= '0;
      busy_q       <= '0;
      nonempty_q   <= 1'b0;
      head_q       <= '0;
      scan_q       <= '0;
      slot_q       <= '0;
      cur_idx_q    <= '0;
      cur_q        <= '0;
      dl_q         <= '0;
      hid_q        <= '0;
      res_status_q <= '0;
      res_fired_q  <= 1'b0;
      res_fh_q     <= '0;
      res_sw_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_fired_q  <= 1'b0;
      out_fh_q     <= '0;
      out_sw_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (state_q == sat_pkg::ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        sat_pkg::ST_IDLE: begin
          if (accept) begin
            res_fired_q <= 1'b0;
            res_fh_q    <= '0;
            if (!req_i.mode) begin
              tick_q       <= tick_q + 32'd1;
              res_status_q <= sat_pkg::STATUS_TICK;
              if (switch_inc >= period_q) begin
                switch_q <= '0;
                res_sw_q <= 1'b1;
              end else begin
                switch_q <= switch_inc;
                res_sw_q <= 1'b0;
              end
            end else begin
              res_status_q <= req_i.requester_is_task ? sat_pkg::STATUS_SET_OK
                                                      : sat_pkg::STATUS_NOT_TASK;
              res_sw_q     <= 1'b0;
              dl_q         <= tick_q + 32'(req_i.delay_ticks);
              hid_q        <= req_i.handler_id;
              scan_q       <= '0;
            end
          end
        end
        sat_pkg::ST_SCAN: begin
          if (scan_free) begin
            slot_q         <= scan_q;
            busy_q[scan_q] <= 1'b1;
            if (!nonempty_q) begin
              head_q     <= scan_q;
              nonempty_q <= 1'b1;
            end
          end else if (scan_last) begin
            res_status_q <= sat_pkg::STATUS_NO_SLOT;
          end else begin
            scan_q <= scan_q + SW'(1);
          end
        end
        sat_pkg::ST_SET_HEAD: begin
          if (dl_q < rd_q.deadline) begin
            head_q <= slot_q;
          end else begin
            cur_q     <= rd_q;
            cur_idx_q <= head_q;
          end
        end
        sat_pkg::ST_NEXT: begin
          if (!(rd_q.deadline > dl_q)) begin
            cur_q     <= rd_q;
            cur_idx_q <= cur_q.next_idx;
          end
        end
        sat_pkg::ST_TICK_HEAD: begin
          if (tick_q >= rd_q.deadline) begin
            res_fired_q    <= 1'b1;
            res_fh_q       <= rd_q.handler;
            busy_q[head_q] <= 1'b0;
            if (rd_q.has_next) begin
              head_q <= rd_q.next_idx;
            end else begin
              nonempty_q <= 1'b0;
              head_q     <= '0;
            end
          end
        end
        sat_pkg::ST_RESULT: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_fired_q  <= res_fired_q;
            out_fh_q     <= res_fh_q;
            out_sw_q     <= res_sw_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_fire_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.alarm_fired |-> rsp_o.status == sat_pkg::STATUS_TICK)
    else $error("alarm reported on a set result");

  a_empty_list_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sat_pkg::ST_IDLE && !nonempty_q |-> busy_q == '0)
    else $error("busy slot with an empty list");

  a_head_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sat_pkg::ST_IDLE && nonempty_q |-> busy_q[head_q])
    else $error("list head is a free slot");

  a_refused_keeps_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.mode && !req_i.requester_is_task |=> $stable(busy_q))
    else $error("refused request changed the slot pool");

endmodule

`default_nettype wire

/* sim/tb_sorted_alarm_timer_queue.sv */
`timescale 1ns / 1ps

module tb_sorted_alarm_timer_queue;

  localparam int SLOTS = sat_pkg::ALARM_SLOTS_DEF;
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET = 1'b1;
  localparam int SETTLE_CYCLES = 3 * SLOTS + 16;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic        mode;
    logic [15:0] delay_ticks;
    logic [7:0]  handler_id;
    logic        requester_is_task;
  } alarm_req_t;

  typedef struct packed {
    sat_pkg::status_e status;
    logic             alarm_fired;
    logic [7:0]       fired_handler;
    logic             switch_request;
  } alarm_rsp_t;

  typedef struct packed {
    alarm_req_t item;
    logic       typed;
    alarm_rsp_t want;
  } dir_row_t;

  localparam alarm_rsp_t SET_ACCEPTED = '{sat_pkg::STATUS_SET_OK, 1'b0, 8'd0, 1'b0};
  localparam alarm_rsp_t SET_REFUSED = '{sat_pkg::STATUS_NOT_TASK, 1'b0, 8'd0, 1'b0};
  localparam alarm_rsp_t TICK_QUIET = '{sat_pkg::STATUS_TICK, 1'b0, 8'd0, 1'b0};
  localparam alarm_rsp_t FROM_QUEUE = '0;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{MODE_TICK, 16'hffff, 8'hff, 1'b1}, 1'b1, TICK_QUIET},
    '{'{MODE_SET,  16'hffff, 8'hff, 1'b0}, 1'b1, SET_REFUSED},
    '{'{MODE_SET,  16'h0000, 8'h00, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_SET,  16'hffff, 8'hff, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_SET,  16'h0002, 8'h11, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_SET,  16'h0002, 8'h22, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_SET,  16'h0001, 8'h33, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_SET,  16'h0000, 8'h44, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_SET,  16'h0000, 8'h00, 1'b0}, 1'b1, SET_REFUSED},
    '{'{MODE_SET,  16'h0005, 8'h5a, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_SET,  16'h0003, 8'ha5, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_SET,  16'h0003, 8'h3c, 1'b1}, 1'b1, SET_ACCEPTED},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE},
    '{'{MODE_TICK, 16'h0000, 8'h00, 1'b0}, 1'b0, FROM_QUEUE}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  sat_req_if req ();
  sat_rsp_if rsp ();

  sorted_alarm_timer_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [31:0] now_ticks;
  logic [7:0]  switch_ticks;
  logic [7:0]  switch_period_q;
  logic [31:0] alarm_deadline [SLOTS];
  logic [7:0]  alarm_handler [SLOTS];
  logic        alarm_busy [SLOTS];
  int          alarm_next [SLOTS];
  logic        alarm_has_next [SLOTS];
  logic        list_valid;
  int          list_head;

  alarm_rsp_t pending_results [$];
  alarm_rsp_t oldest_result;
  int         mismatches;
  int         results_seen;
  int         quiet_cycles;
  int         send_idle_pct;
  int         recv_idle_pct;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic void link_alarm(input int s);
    logic [31:0] due;
    int          cur;
    due = alarm_deadline[s];
    if (!list_valid) begin
      list_head = s;
      alarm_has_next[s] = 1'b0;
      alarm_next[s] = 0;
      list_valid = 1'b1;
    end else if (due < alarm_deadline[list_head]) begin
      alarm_next[s] = list_head;
      alarm_has_next[s] = 1'b1;
      list_head = s;
    end else begin
      cur = list_head;
      for (int g = 0; g < SLOTS; g++) begin
        if (!alarm_has_next[cur] || alarm_deadline[alarm_next[cur]] > due) begin
          break;
        end
        cur = alarm_next[cur];
      end
      alarm_next[s] = alarm_next[cur];
      alarm_has_next[s] = alarm_has_next[cur];
      alarm_next[cur] = s;
      alarm_has_next[cur] = 1'b1;
    end
  endfunction

  function automatic alarm_rsp_t alarm_queue_step(input alarm_req_t r);
    alarm_rsp_t o;
    int         slot;
    int         h;
    o = SET_ACCEPTED;
    slot = -1;
    if (r.mode == MODE_SET) begin
      if (!r.requester_is_task) begin
        o.status = sat_pkg::STATUS_NOT_TASK;
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!alarm_busy[i]) begin
            slot = i;
          end
        end
        if (slot < 0) begin
          o.status = sat_pkg::STATUS_NO_SLOT;
        end else begin
          alarm_deadline[slot] = now_ticks + {16'd0, r.delay_ticks};
          alarm_handler[slot] = r.handler_id;
          alarm_busy[slot] = 1'b1;
          link_alarm(slot);
        end
      end
    end else begin
      now_ticks = now_ticks + 32'd1;
      switch_ticks = switch_ticks + 8'd1;
      o.status = sat_pkg::STATUS_TICK;
      if (list_valid && now_ticks >= alarm_deadline[list_head]) begin
        h = list_head;
        o.alarm_fired = 1'b1;
        o.fired_handler = alarm_handler[h];
        alarm_busy[h] = 1'b0;
        if (alarm_has_next[h]) begin
          list_head = alarm_next[h];
        end else begin
          list_valid = 1'b0;
          list_head = 0;
        end
        alarm_has_next[h] = 1'b0;
      end
      if (switch_ticks >= switch_period_q) begin
        switch_ticks = 8'd0;
        o.switch_request = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic alarm_req_t random_set();
    alarm_req_t r;
    int         pick;
    pick = $urandom_range(0, 99);
    r.mode = MODE_SET;
    r.handler_id = 8'($urandom_range(0, 255));
    r.requester_is_task = ($urandom_range(0, 9) != 0);
    if (pick < 1) begin
      r.delay_ticks = 16'($urandom);
    end else if (pick < 20) begin
      r.delay_ticks = 16'($urandom_range(0, 3));
    end else begin
      r.delay_ticks = 16'($urandom_range(0, 40));
    end
    return r;
  endfunction

  function automatic alarm_req_t random_tick();
    alarm_req_t r;
    r.mode = MODE_TICK;
    r.delay_ticks = 16'($urandom);
    r.handler_id = 8'($urandom);
    r.requester_is_task = 1'($urandom);
    return r;
  endfunction

  function automatic alarm_req_t random_noise();
    alarm_req_t r;
    r.mode = 1'($urandom);
    r.delay_ticks = 16'($urandom_range(0, 60));
    r.handler_id = 8'($urandom);
    r.requester_is_task = 1'($urandom);
    return r;
  endfunction

  task automatic send_item(input alarm_req_t item, input logic typed, input alarm_rsp_t want);
    alarm_rsp_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.mode <= item.mode;
    req.delay_ticks <= item.delay_ticks;
    req.handler_id <= item.handler_id;
    req.requester_is_task <= item.requester_is_task;
    @(posedge clk_i);
    while (!req.ready) begin
      @(posedge clk_i);
    end
    got = alarm_queue_step(item);
    pending_results.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int budget);
    int sent;
    int n;
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        n = $urandom_range(1, 20);
        repeat (n) send_item(random_set(), 1'b0, FROM_QUEUE);
      end else if (pick < 90) begin
        n = $urandom_range(1, 30);
        repeat (n) send_item(random_tick(), 1'b0, FROM_QUEUE);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(random_noise(), 1'b0, FROM_QUEUE);
      end
      sent += n;
    end
    req.valid <= 1'b0;
  endtask

  task automatic write_switch_period(input logic [7:0] period);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= period;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    switch_period_q = period;
  endtask

  always @(negedge clk_i) begin
    rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rsp.valid && rsp.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp.status != oldest_result.status) begin
          report_mismatch($sformatf("result %0d field status got %0d expected %0d",
                                    results_seen, rsp.status, oldest_result.status));
        end
        if (rsp.alarm_fired != oldest_result.alarm_fired) begin
          report_mismatch($sformatf("result %0d field alarm_fired got %0d expected %0d",
                                    results_seen, rsp.alarm_fired, oldest_result.alarm_fired));
        end
        if (rsp.fired_handler != oldest_result.fired_handler) begin
          report_mismatch($sformatf("result %0d field fired_handler got %0d expected %0d",
                                    results_seen, rsp.fired_handler,
                                    oldest_result.fired_handler));
        end
        if (rsp.switch_request != oldest_result.switch_request) begin
          report_mismatch($sformatf("result %0d field switch_request got %0d expected %0d",
                                    results_seen, rsp.switch_request,
                                    oldest_result.switch_request));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'd0;
    req.valid = 1'b0;
    req.mode = MODE_TICK;
    req.delay_ticks = 16'd0;
    req.handler_id = 8'd0;
    req.requester_is_task = 1'b0;
    rsp.ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    quiet_cycles = 0;
    send_idle_pct = 21;
    recv_idle_pct = 66;
    now_ticks = 32'd0;
    switch_ticks = 8'd0;
    switch_period_q = sat_pkg::SWITCH_PERIOD_RESET;
    list_valid = 1'b0;
    list_head = 0;
    for (int i = 0; i < SLOTS; i++) begin
      alarm_deadline[i] = 32'd0;
      alarm_handler[i] = 8'd0;
      alarm_busy[i] = 1'b0;
      alarm_next[i] = 0;
      alarm_has_next[i] = 1'b0;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_item(DIRECTED[k].item, DIRECTED[k].typed, DIRECTED[k].want);
    end
    req.valid <= 1'b0;

    write_switch_period(8'd1);
    run_phase(21, 66, 210);
    write_switch_period(8'd255);
    run_phase(66, 21, 210);
    write_switch_period(8'd0);
    run_phase(0, 0, 110);
    write_switch_period(8'($urandom_range(2, 254)));
    run_phase(0, 0, 110);

    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
